// ===== rtl/vurft_pkg.sv =====
`timescale 1ns / 1ps
package vurft_pkg;

  // Frame geometry and memory size
  localparam int DOTS_PER_LINE = 341;
  localparam int LINE_WRAP     = 261;
  localparam int VRAM_DEPTH    = 16384;
  localparam int VRAM_AW       = $clog2(VRAM_DEPTH);

  // Field widths
  localparam int DOT_W  = 9;
  localparam int LINE_W = 9;
  localparam int ADDR_W = 14;

  // Special lines; the all-ones line code is the pre-render line
  localparam logic [LINE_W-1:0] PRE_LINE     = 9'd511;
  localparam logic [LINE_W-1:0] VBLANK_LINE  = 9'd241;
  localparam logic [LINE_W-1:0] ALT_PRE_LINE = 9'd261;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    SEL_CTRL     = 3'd0,
    SEL_MASK     = 3'd1,
    SEL_STATUS   = 3'd2,
    SEL_OAM_ADDR = 3'd3,
    SEL_OAM_DATA = 3'd4,
    SEL_SCROLL   = 3'd5,
    SEL_ADDR     = 3'd6,
    SEL_DATA     = 3'd7
  } sel_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] register_select;
    logic [7:0] write_data;
  } item_t;

  typedef struct packed {
    logic [7:0]        read_data;
    logic              access_error;
    logic              vblank_flag;
    logic              nmi_pulse;
    logic              frame_done;
    logic [ADDR_W-1:0] video_address;
    logic [7:0]        scroll_horizontal;
    logic [7:0]        scroll_vertical;
    logic [7:0]        control_value;
    logic [7:0]        mask_value;
    logic [7:0]        sprite_table_address;
  } result_t;

endpackage

// ===== rtl/vurft_item_if.sv =====
`timescale 1ns / 1ps
interface vurft_item_if;
  import vurft_pkg::*;

  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/vurft_result_if.sv =====
`timescale 1ns / 1ps
interface vurft_result_if;
  import vurft_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/video_unit_register_and_frame_timing.sv =====
`timescale 1ns / 1ps
// Channel   Role    Payload
// -------   -----   ---------------------------------------------------
// item      sink    operation, register_select, write_data
// result    source  read_data, flags, address, scroll and register bytes
//
// State updates at the accepting edge and the result is registered there, so it
// shows in the next cycle; a request may enter in every cycle while the result
// is not stalled.
// rst is synchronous; it clears the dot counter, flags, registers and result valid, and sets the line to pre-render.
// A stalled result holds; a new request is taken only if the result leaves.
module video_unit_register_and_frame_timing (
  input  logic                  clk,
  input  logic                  rst,
  vurft_item_if.sink            item,
  vurft_result_if.source        result
);
  import vurft_pkg::*;

  logic [DOT_W-1:0]  dot_count, dot_count_next;
  logic [LINE_W-1:0] line_count, line_count_next;
  logic              vblank_bit, vblank_bit_next;
  logic              frame_end_bit, frame_end_bit_next;
  logic              write_toggle, write_toggle_next;
  logic [7:0]        control_reg, control_reg_next;
  logic [7:0]        mask_reg, mask_reg_next;
  logic [ADDR_W-1:0] address_reg, address_reg_next;
  logic [7:0]        scroll_x_reg, scroll_x_reg_next;
  logic [7:0]        scroll_y_reg, scroll_y_reg_next;
  logic [7:0]        oam_address_reg, oam_address_reg_next;

  logic [7:0]        read_data_next;
  logic              access_error_next;
  logic              nmi_pulse_next;
  logic              vram_we;
  logic [ADDR_W:0]   vram_wide;
  logic [VRAM_AW-1:0] vram_idx;
  logic [DOT_W:0]    dot_inc;
  logic [LINE_W:0]   line_inc;
  logic              accept;

  logic [7:0]        video_memory [VRAM_DEPTH];

  logic              res_valid;
  result_t           res_data;

  assign accept       = item.valid && item.ready;
  assign item.ready   = !res_valid || result.ready;
  assign result.valid = res_valid;
  assign result.data  = res_data;

  // Reduce the address into the memory range: one compare and subtract
  always_comb begin
    if ({1'b0, address_reg} >= (ADDR_W + 1)'(VRAM_DEPTH)) begin
      vram_wide = {1'b0, address_reg} - (ADDR_W + 1)'(VRAM_DEPTH);
    end else begin
      vram_wide = {1'b0, address_reg};
    end
    vram_idx = vram_wide[VRAM_AW-1:0];
  end

  // Decode the request and compute next state and result fields
  always_comb begin
    dot_count_next       = dot_count;
    line_count_next      = line_count;
    vblank_bit_next      = vblank_bit;
    frame_end_bit_next   = frame_end_bit;
    write_toggle_next    = write_toggle;
    control_reg_next     = control_reg;
    mask_reg_next        = mask_reg;
    address_reg_next     = address_reg;
    scroll_x_reg_next    = scroll_x_reg;
    scroll_y_reg_next    = scroll_y_reg;
    oam_address_reg_next = oam_address_reg;
    read_data_next       = 8'd0;
    access_error_next    = 1'b0;
    nmi_pulse_next       = 1'b0;
    vram_we              = 1'b0;
    dot_inc              = {1'b0, dot_count} + (DOT_W + 1)'(1);
    line_inc             = (line_count == PRE_LINE) ? '0
                                                    : {1'b0, line_count} + (LINE_W + 1)'(1);

    case (item.data.operation)
      OP_TICK: begin
        // Clear frame end on a pre-render line
        if (line_count == PRE_LINE || line_count == ALT_PRE_LINE) begin
          frame_end_bit_next = 1'b0;
        end
        // Enter vertical blank
        if (dot_count == DOT_W'(1) && line_count == VBLANK_LINE) begin
          vblank_bit_next = 1'b1;
          nmi_pulse_next  = control_reg[7];
        end
        // Advance dot, then line at end of line, wrap at frame end
        if (dot_inc >= (DOT_W + 1)'(DOTS_PER_LINE)) begin
          dot_count_next = '0;
          if (line_inc >= (LINE_W + 1)'(LINE_WRAP)) begin
            frame_end_bit_next = 1'b1;
            line_count_next    = PRE_LINE;
          end else begin
            line_count_next = line_inc[LINE_W-1:0];
          end
        end else begin
          dot_count_next = dot_inc[DOT_W-1:0];
        end
      end
      OP_READ: begin
        if (item.data.register_select == SEL_STATUS) begin
          read_data_next    = {vblank_bit, 7'd0};
          vblank_bit_next   = 1'b0;
          write_toggle_next = 1'b0;
        end else begin
          access_error_next = 1'b1;
        end
      end
      OP_WRITE: begin
        case (item.data.register_select)
          SEL_CTRL:     control_reg_next     = item.data.write_data;
          SEL_MASK:     mask_reg_next        = item.data.write_data;
          SEL_OAM_ADDR: oam_address_reg_next = item.data.write_data;
          SEL_SCROLL: begin
            if (!write_toggle) begin
              scroll_x_reg_next = item.data.write_data;
            end else begin
              scroll_y_reg_next = item.data.write_data;
            end
            write_toggle_next = !write_toggle;
          end
          SEL_ADDR: begin
            if (!write_toggle) begin
              address_reg_next = {item.data.write_data[5:0], address_reg[7:0]};
            end else begin
              address_reg_next = {address_reg[ADDR_W-1:8], item.data.write_data};
            end
            write_toggle_next = !write_toggle;
          end
          SEL_DATA: begin
            vram_we          = 1'b1;
            address_reg_next = address_reg + ADDR_W'(1);
          end
          default: access_error_next = 1'b1;
        endcase
      end
      default: access_error_next = 1'b1;
    endcase
  end

  // Hold state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_count       <= '0;
      line_count      <= PRE_LINE;
      vblank_bit      <= 1'b0;
      frame_end_bit   <= 1'b0;
      write_toggle    <= 1'b0;
      control_reg     <= '0;
      mask_reg        <= '0;
      address_reg     <= '0;
      scroll_x_reg    <= '0;
      scroll_y_reg    <= '0;
      oam_address_reg <= '0;
      res_valid       <= 1'b0;
    end else begin
      if (accept) begin
        dot_count       <= dot_count_next;
        line_count      <= line_count_next;
        vblank_bit      <= vblank_bit_next;
        frame_end_bit   <= frame_end_bit_next;
        write_toggle    <= write_toggle_next;
        control_reg     <= control_reg_next;
        mask_reg        <= mask_reg_next;
        address_reg     <= address_reg_next;
        scroll_x_reg    <= scroll_x_reg_next;
        scroll_y_reg    <= scroll_y_reg_next;
        oam_address_reg <= oam_address_reg_next;
        res_valid       <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Load result payload on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      res_data.read_data            <= read_data_next;
      res_data.access_error         <= access_error_next;
      res_data.vblank_flag          <= vblank_bit_next;
      res_data.nmi_pulse            <= nmi_pulse_next;
      res_data.frame_done           <= frame_end_bit_next;
      res_data.video_address        <= address_reg_next;
      res_data.scroll_horizontal    <= scroll_x_reg_next;
      res_data.scroll_vertical      <= scroll_y_reg_next;
      res_data.control_value        <= control_reg_next;
      res_data.mask_value           <= mask_reg_next;
      res_data.sprite_table_address <= oam_address_reg_next;
    end
  end

  // Store data writes into video memory
  always_ff @(posedge clk) begin
    if (accept && vram_we) begin
      video_memory[vram_idx] <= item.data.write_data;
    end
  end

endmodule

// ===== rtl/vurft_checker.sv =====
`timescale 1ns / 1ps
module vurft_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input vurft_pkg::result_t       out_data
);
  import vurft_pkg::*;

  // Every accepted request produces a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

  // No request is taken while a result is stalled
  a_no_take_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

  // A stalled result holds its payload
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // NMI only fires together with vblank
  a_nmi_with_vblank: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.nmi_pulse |-> out_data.vblank_flag && !out_data.access_error)
    else $error("nmi pulse without vblank");

  // A failed access returns no read data
  a_error_zero_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.access_error |-> out_data.read_data == 8'd0)
    else $error("error result carries read data");

endmodule

bind video_unit_register_and_frame_timing vurft_checker u_vurft_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_data  (result.data)
);

// ===== verif/video_unit_register_and_frame_timing_test.sv =====
`timescale 1ns / 1ps
module video_unit_register_and_frame_timing_test;
  import vurft_pkg::*;

  // Operation code that the block does not implement
  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int IDLE_PERCENT = 18;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vurft_item_if   request_bus ();
  vurft_result_if response_bus ();

  video_unit_register_and_frame_timing DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (request_bus),
    .result (response_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the video unit state
  logic [8:0]        dot_pos;
  logic [8:0]        line_pos;
  logic              vblank_state;
  logic              frame_end_state;
  logic              toggle_state;
  logic [7:0]        ctrl_byte;
  logic [7:0]        mask_byte;
  logic [ADDR_W-1:0] vram_pointer;
  logic [7:0]        scroll_x_byte;
  logic [7:0]        scroll_y_byte;
  logic [7:0]        oam_pointer;
  logic [7:0]        vram_shadow [VRAM_DEPTH];

  result_t pending_responses [$];
  int      mismatch_count = 0;
  int      requests_sent = 0;
  int      cycle_count = 0;
  logic    source_steady = 1'b0;
  logic    sink_steady = 1'b0;

  // Advance the shadow state for one request and build its response
  function automatic result_t video_unit_response(input logic [1:0] op,
                                                  input logic [2:0] sel,
                                                  input logic [7:0] wd);
    result_t r;
    int next_dot;
    int next_line;
    r = '0;
    case (op)
      OP_TICK: begin
        if (line_pos == PRE_LINE || line_pos == ALT_PRE_LINE) frame_end_state = 1'b0;
        if (dot_pos == 9'd1 && line_pos == VBLANK_LINE) begin
          vblank_state = 1'b1;
          r.nmi_pulse = ctrl_byte[7];
        end
        next_dot = int'(dot_pos) + 1;
        if (next_dot >= DOTS_PER_LINE) begin
          next_line = (line_pos == PRE_LINE) ? 0 : int'(line_pos) + 1;
          next_dot = 0;
          if (next_line >= LINE_WRAP) begin
            frame_end_state = 1'b1;
            next_line = int'(PRE_LINE);
          end
          line_pos = next_line[8:0];
        end
        dot_pos = next_dot[8:0];
      end
      OP_READ: begin
        if (sel == SEL_STATUS) begin
          r.read_data = {vblank_state, 7'd0};
          vblank_state = 1'b0;
          toggle_state = 1'b0;
        end else begin
          r.access_error = 1'b1;
        end
      end
      OP_WRITE: begin
        case (sel)
          SEL_CTRL:     ctrl_byte = wd;
          SEL_MASK:     mask_byte = wd;
          SEL_OAM_ADDR: oam_pointer = wd;
          SEL_SCROLL: begin
            if (!toggle_state) scroll_x_byte = wd;
            else scroll_y_byte = wd;
            toggle_state = !toggle_state;
          end
          SEL_ADDR: begin
            if (!toggle_state) vram_pointer = {wd[5:0], vram_pointer[7:0]};
            else vram_pointer = {vram_pointer[13:8], wd};
            toggle_state = !toggle_state;
          end
          SEL_DATA: begin
            vram_shadow[int'(vram_pointer) % VRAM_DEPTH] = wd;
            vram_pointer = vram_pointer + ADDR_W'(1);
          end
          default: r.access_error = 1'b1;
        endcase
      end
      default: r.access_error = 1'b1;
    endcase
    r.vblank_flag          = vblank_state;
    r.frame_done           = frame_end_state;
    r.video_address        = vram_pointer;
    r.scroll_horizontal    = scroll_x_byte;
    r.scroll_vertical      = scroll_y_byte;
    r.control_value        = ctrl_byte;
    r.mask_value           = mask_byte;
    r.sprite_table_address = oam_pointer;
    return r;
  endfunction

  // Drive one request, hold it until accepted, then record its response
  task automatic send_request(input logic [1:0] op, input logic [2:0] sel,
                              input logic [7:0] wd);
    if (!source_steady && $urandom_range(99) < IDLE_PERCENT) begin
      request_bus.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    request_bus.valid <= 1'b1;
    request_bus.data  <= item_t'{operation: op, register_select: sel, write_data: wd};
    do @(posedge clk); while (!request_bus.ready);
    pending_responses.push_back(video_unit_response(op, sel, wd));
    requests_sent++;
  endtask

  task automatic send_tick();
    send_request(OP_TICK, SEL_CTRL, 8'($urandom));
  endtask

  task automatic send_any_request();
    send_request(2'($urandom), 3'($urandom), 8'($urandom));
  endtask

  // Hold off new requests until every response is back
  task automatic wait_for_responses();
    request_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_responses.size() != 0);
  endtask

  task automatic test_register_access();
    send_request(OP_READ, SEL_STATUS, 8'h00);
    for (int s = 0; s < 8; s++) begin
      if (s != SEL_STATUS) send_request(OP_READ, 3'(s), 8'hFF);
    end
    send_request(OP_WRITE, SEL_STATUS, 8'hFF);
    send_request(OP_WRITE, SEL_OAM_DATA, 8'hFF);
    send_request(OP_UNKNOWN, SEL_CTRL, 8'hFF);
    send_request(OP_UNKNOWN, SEL_DATA, 8'h00);
    send_request(OP_WRITE, SEL_CTRL, 8'hFF);
    send_request(OP_WRITE, SEL_MASK, 8'hFF);
    send_request(OP_WRITE, SEL_OAM_ADDR, 8'hFF);
    send_request(OP_WRITE, SEL_CTRL, 8'h00);
    send_request(OP_WRITE, SEL_SCROLL, 8'hFF);
    send_request(OP_WRITE, SEL_SCROLL, 8'h00);
    // A status read mid-pair restarts the write toggle
    send_request(OP_WRITE, SEL_SCROLL, 8'hAB);
    send_request(OP_READ, SEL_STATUS, 8'h00);
    send_request(OP_WRITE, SEL_SCROLL, 8'h55);
    // Top address, then data writes that wrap to zero
    send_request(OP_READ, SEL_STATUS, 8'h00);
    send_request(OP_WRITE, SEL_ADDR, 8'hFF);
    send_request(OP_WRITE, SEL_ADDR, 8'hFF);
    send_request(OP_WRITE, SEL_DATA, 8'h12);
    send_request(OP_WRITE, SEL_DATA, 8'hFF);
    send_tick();
    send_tick();
    wait_for_responses();
  endtask

  task automatic test_frame_timing();
    // Leave the pre-render line back to back on both sides, NMI enabled
    source_steady = 1'b1;
    sink_steady   = 1'b1;
    send_request(OP_WRITE, SEL_CTRL, 8'h80);
    while (line_pos == PRE_LINE) send_tick();
    send_tick();
    send_request(OP_READ, SEL_STATUS, 8'h00);
    source_steady = 1'b0;
    sink_steady   = 1'b0;
    // Continue along the first line with gaps and scattered register accesses
    send_request(OP_WRITE, SEL_CTRL, 8'h7F);
    repeat (60) begin
      if ($urandom_range(99) < 3) send_any_request();
      else send_tick();
    end
    wait_for_responses();
  endtask

  task automatic test_random_traffic(input int goal);
    int start;
    int pressure_at;
    logic [7:0] high_byte;
    start = requests_sent;
    pressure_at = start + goal / 2;
    while (requests_sent - start < goal) begin
      if (requests_sent >= pressure_at) begin
        wait_for_responses();
        pressure_at = start + goal + 1;
      end
      case ($urandom_range(9))
        0, 1: begin
          send_request(OP_READ, SEL_STATUS, 8'($urandom));
          send_request(OP_WRITE, SEL_SCROLL, 8'($urandom));
          send_request(OP_WRITE, SEL_SCROLL, 8'($urandom));
        end
        2, 3: begin
          high_byte = 8'($urandom);
          send_request(OP_READ, SEL_STATUS, 8'($urandom));
          send_request(OP_WRITE, SEL_ADDR, high_byte);
          send_request(OP_WRITE, SEL_ADDR, 8'($urandom));
          repeat ($urandom_range(4, 1)) send_request(OP_WRITE, SEL_DATA, 8'($urandom));
        end
        4: send_request(OP_WRITE, 3'($urandom_range(3)) & 3'b011, 8'($urandom));
        5: repeat ($urandom_range(8, 1)) send_tick();
        6: send_request(OP_READ, SEL_STATUS, 8'($urandom));
        default: send_any_request();
      endcase
    end
    wait_for_responses();
  endtask

  // Random backpressure on the response side
  always @(posedge clk) begin
    if (rst) response_bus.ready <= 1'b0;
    else if (sink_steady) response_bus.ready <= 1'b1;
    else response_bus.ready <= ($urandom_range(99) >= IDLE_PERCENT);
  end

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Check each accepted response against the oldest prediction
  always @(posedge clk) begin : check_responses
    result_t want;
    result_t got;
    if (!rst && response_bus.valid && response_bus.ready) begin
      got = response_bus.data;
      if (pending_responses.size() == 0) begin
        $error("response with no request pending");
        mismatch_count++;
      end else begin
        want = pending_responses.pop_front();
        compare_field("read_data", 16'(want.read_data), 16'(got.read_data));
        compare_field("access_error", 16'(want.access_error), 16'(got.access_error));
        compare_field("vblank_flag", 16'(want.vblank_flag), 16'(got.vblank_flag));
        compare_field("nmi_pulse", 16'(want.nmi_pulse), 16'(got.nmi_pulse));
        compare_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
        compare_field("video_address", 16'(want.video_address),
                      16'(got.video_address));
        compare_field("scroll_horizontal", 16'(want.scroll_horizontal),
                      16'(got.scroll_horizontal));
        compare_field("scroll_vertical", 16'(want.scroll_vertical),
                      16'(got.scroll_vertical));
        compare_field("control_value", 16'(want.control_value),
                      16'(got.control_value));
        compare_field("mask_value", 16'(want.mask_value), 16'(got.mask_value));
        compare_field("sprite_table_address", 16'(want.sprite_table_address),
                      16'(got.sprite_table_address));
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** video_unit_register_and_frame_timing: FAILED **");
      $finish;
    end
  end

  initial begin
    request_bus.valid  = 1'b0;
    request_bus.data   = '0;
    dot_pos         = '0;
    line_pos        = PRE_LINE;
    vblank_state    = 1'b0;
    frame_end_state = 1'b0;
    toggle_state    = 1'b0;
    ctrl_byte       = '0;
    mask_byte       = '0;
    vram_pointer    = '0;
    scroll_x_byte   = '0;
    scroll_y_byte   = '0;
    oam_pointer     = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_access();
    test_frame_timing();
    test_random_traffic(400);

    // Drain and let the output register settle
    wait_for_responses();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** video_unit_register_and_frame_timing: PASSED **");
    end else begin
      $display("** video_unit_register_and_frame_timing: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/vurft_pkg.sv
rtl/vurft_item_if.sv
rtl/vurft_result_if.sv
rtl/video_unit_register_and_frame_timing.sv
rtl/vurft_checker.sv
verif/video_unit_register_and_frame_timing_test.sv
